// ===== hw/rtl/mass_properties_accumulator_unit_assert.svh =====
// Assertion macros for the mass properties accumulator.
// No dependencies; included by the top level.
`ifndef MASS_PROPERTIES_ACCUMULATOR_UNIT_ASSERT_SVH
`define MASS_PROPERTIES_ACCUMULATOR_UNIT_ASSERT_SVH
// implication that must hold in the next cycle
`define MPA_NEXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");
// implication in the same cycle
`define MPA_SAME(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");
`endif

// ===== hw/rtl/mpa_pkg.sv =====
// Package for the mass properties accumulator: states, commands, limits.
// No dependencies.
package mpa_pkg;
    typedef enum logic [3:0] {
        ST_IDLE, ST_DIFF, ST_MUL1, ST_MUL2, ST_ACC, ST_DIV, ST_DIVFIN, ST_OUT
    } t_state;

    typedef struct packed {
        logic load;      // capture input item
        logic diff;      // form stations
        logic mul1;      // first products
        logic mul2;      // second products
        logic acc;       // accumulate
        logic div_start; // start com division
        logic div_step;  // one quotient bit
        logic div_fin;   // finish com
    } t_cmd;

    typedef struct packed {
        logic is_final;
        logic div_done;
    } t_status;

    localparam logic [21:0] MASS_MAX = 22'h3FFFFF;
    localparam int DIV_BITS = 44;
    localparam logic [5:0] DIV_LAST = 6'(DIV_BITS - 1);
endpackage

// ===== hw/rtl/mpa_ctrl.sv =====
// Controller state machine for the mass properties accumulator.
// Depends on mpa_pkg.
module mpa_ctrl import mpa_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_ready,
    input  t_status i_status,
    output logic    o_ready,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= ST_IDLE;
        else r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_ready = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state = ST_DIFF;
                end
            end
            ST_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state = ST_MUL1;
            end
            ST_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state = ST_MUL2;
            end
            ST_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state = ST_ACC;
            end
            ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_status.is_final ? ST_DIV : ST_IDLE;
            end
            ST_DIV: begin
                o_cmd.div_start = 1'b1;
                n_state = ST_DIVFIN;
            end
            ST_DIVFIN: begin
                o_cmd.div_step = 1'b1;
                if (i_status.div_done) begin
                    o_cmd.div_fin = 1'b1;
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule

// ===== hw/rtl/mpa_datapath.sv =====
// Datapath: stations, shared products, saturating accumulators, serial divider.
// Depends on mpa_pkg.
module mpa_datapath import mpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    input  logic [15:0]         i_atom_mass,
    input  logic signed [19:0]  i_pos_x,
    input  logic signed [19:0]  i_pos_y,
    input  logic signed [19:0]  i_pos_z,
    input  logic                i_is_origin,
    input  logic                i_is_final,
    output t_status             o_status,
    output logic [21:0]         o_total_mass,
    output logic signed [20:0]  o_com_x,
    output logic signed [20:0]  o_com_y,
    output logic signed [20:0]  o_com_z,
    output logic [62:0]         o_inertia_xx,
    output logic [62:0]         o_inertia_yy,
    output logic [62:0]         o_inertia_zz,
    output logic signed [63:0]  o_inertia_xy,
    output logic signed [63:0]  o_inertia_yz,
    output logic signed [63:0]  o_inertia_xz,
    output logic                o_mass_zero
);
    logic [15:0] r_m;
    logic signed [19:0] r_p [3];
    logic r_org, r_fin;
    logic signed [19:0] r_origin [3];
    logic [21:0] r_mass;
    logic signed [43:0] r_fm [3];
    logic signed [63:0] r_acc [6];
    logic signed [20:0] r_s [3];
    // mul1: mass*station (37b) and station squares (42b)
    logic signed [36:0] r_ms [3];
    logic signed [41:0] r_sq [3];
    // mul2: mass*square terms; ms*s cross terms
    logic signed [63:0] r_t [6];
    // divider
    logic [43:0] r_rem [3], r_quo [3];
    logic [43:0] r_num [3];
    logic r_neg [3];
    logic [5:0] r_cnt;
    logic signed [20:0] r_com [3];

    function automatic logic signed [63:0] sat64(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return {1'b0, {63{1'b1}}};
        if (a[63] && b[63] && !s[63]) return {1'b1, 63'b0};
        return s;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_m <= i_atom_mass;
            r_p[0] <= i_pos_x; r_p[1] <= i_pos_y; r_p[2] <= i_pos_z;
            r_org <= i_is_origin; r_fin <= i_is_final;
        end
        if (i_cmd.diff)
            for (int i = 0; i < 3; i++)
                r_s[i] <= r_org ? 21'sd0 : 21'(r_p[i]) - 21'(r_origin[i]);
        if (i_cmd.mul1)
            for (int i = 0; i < 3; i++) begin
                r_ms[i] <= $signed({1'b0, r_m}) * r_s[i];
                r_sq[i] <= r_s[i] * r_s[i];
            end
        if (i_cmd.mul2) begin
            // sum of two squares < 2^41: times m fits in 59 bits
            r_t[0] <= 64'($signed({1'b0, r_m}) * (43'(r_sq[1]) + 43'(r_sq[2])));
            r_t[1] <= 64'($signed({1'b0, r_m}) * (43'(r_sq[0]) + 43'(r_sq[2])));
            r_t[2] <= 64'($signed({1'b0, r_m}) * (43'(r_sq[0]) + 43'(r_sq[1])));
            r_t[3] <= -64'(r_ms[0] * r_s[1]);
            r_t[4] <= -64'(r_ms[1] * r_s[2]);
            r_t[5] <= -64'(r_ms[0] * r_s[2]);
        end
    end

    always_ff @(posedge i_clk) begin
        logic [22:0] msum;
        logic signed [44:0] fs;
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin r_origin[i] <= '0; r_fm[i] <= '0; end
            for (int i = 0; i < 6; i++) r_acc[i] <= '0;
            r_mass <= '0;
        end else if (i_cmd.acc) begin
            if (r_org) begin
                for (int i = 0; i < 3; i++) begin r_origin[i] <= r_p[i]; r_fm[i] <= '0; end
                for (int i = 0; i < 6; i++) r_acc[i] <= '0;
                r_mass <= 22'(r_m);
            end else begin
                msum = 23'(r_mass) + 23'(r_m);
                r_mass <= msum[22] ? MASS_MAX : msum[21:0];
                for (int i = 0; i < 3; i++) begin
                    fs = 45'(r_fm[i]) + 45'(r_ms[i]);
                    if (fs[44] != fs[43]) r_fm[i] <= fs[44] ? {1'b1, 43'b0} : {1'b0, {43{1'b1}}};
                    else r_fm[i] <= fs[43:0];
                end
                for (int i = 0; i < 6; i++) r_acc[i] <= sat64(r_acc[i], r_t[i]);
            end
        end
    end

    // restoring division of |first moment| by mass, one bit per cycle
    always_ff @(posedge i_clk) begin
        logic [44:0] trial;
        logic [43:0] rs;
        logic signed [44:0] q;
        if (!i_rst_n) r_cnt <= '0;
        else if (i_cmd.div_start) begin
            r_cnt <= '0;
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_fm[i][43];
                r_num[i] <= r_fm[i][43] ? 44'(-r_fm[i]) : r_fm[i];
                r_rem[i] <= '0; r_quo[i] <= '0;
            end
        end else if (i_cmd.div_step) begin
            r_cnt <= r_cnt + 6'd1;
            for (int i = 0; i < 3; i++) begin
                rs = {r_rem[i][42:0], r_num[i][43]};
                trial = {1'b0, rs} - {23'b0, r_mass};
                r_num[i] <= {r_num[i][42:0], 1'b0};
                if (!trial[44]) begin r_rem[i] <= trial[43:0]; r_quo[i] <= {r_quo[i][42:0], 1'b1}; end
                else begin r_rem[i] <= rs; r_quo[i] <= {r_quo[i][42:0], 1'b0}; end
            end
        end
        if (i_cmd.div_fin)
            for (int i = 0; i < 3; i++) begin
                // last quotient bit lands in this same edge; rebuild it here
                rs = {r_rem[i][42:0], r_num[i][43]};
                trial = {1'b0, rs} - {23'b0, r_mass};
                q = $signed({1'b0, r_quo[i][42:0], ~trial[44]});
                if (r_neg[i]) q = -q;
                if (r_mass == 22'd0) r_com[i] <= '0;
                else if (q > 45'sd1048575) r_com[i] <= 21'sd1048575;
                else if (q < -45'sd1048576) r_com[i] <= -21'sd1048576;
                else r_com[i] <= q[20:0];
            end
    end

    assign o_status.is_final = r_fin;
    assign o_status.div_done = (r_cnt == DIV_LAST);
    assign o_total_mass = r_mass;
    assign o_com_x = r_com[0];
    assign o_com_y = r_com[1];
    assign o_com_z = r_com[2];
    assign o_inertia_xx = r_acc[0][63] ? 63'd0 : r_acc[0][62:0];
    assign o_inertia_yy = r_acc[1][63] ? 63'd0 : r_acc[1][62:0];
    assign o_inertia_zz = r_acc[2][63] ? 63'd0 : r_acc[2][62:0];
    assign o_inertia_xy = r_acc[3];
    assign o_inertia_yz = r_acc[4];
    assign o_inertia_xz = r_acc[5];
    assign o_mass_zero = (r_mass == 22'd0);
endmodule

// ===== hw/rtl/mass_properties_accumulator_unit.sv =====
// Top level of the point-mass inertia accumulator.
// Depends on mpa_pkg, mpa_ctrl, mpa_datapath and the assertion header.
//
// channel | direction | handshake              | payload
// in      | input     | i_valid / o_ready      | mass, position, origin/final flags
// out     | output    | o_out_valid / i_out_ready | mass, com, inertia, zero flag
//
// A point passes in turn through accept, station, two product steps through the
// multipliers and accumulate. A final point then goes through the serial
// centre-of-mass division (one quotient bit per cycle) and then holds the
// result until it is taken. Reset clears the origin and all accumulators.
// The input is stalled while a point or a result is in flight.
`include "mass_properties_accumulator_unit_assert.svh"
module mass_properties_accumulator_unit import mpa_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_atom_mass,
    input  logic signed [19:0]  i_pos_x,
    input  logic signed [19:0]  i_pos_y,
    input  logic signed [19:0]  i_pos_z,
    input  logic                i_is_origin,
    input  logic                i_is_final,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [21:0]         o_total_mass,
    output logic signed [20:0]  o_com_x,
    output logic signed [20:0]  o_com_y,
    output logic signed [20:0]  o_com_z,
    output logic [62:0]         o_inertia_xx,
    output logic [62:0]         o_inertia_yy,
    output logic [62:0]         o_inertia_zz,
    output logic signed [63:0]  o_inertia_xy,
    output logic signed [63:0]  o_inertia_yz,
    output logic signed [63:0]  o_inertia_xz,
    output logic                o_mass_zero
);
    t_cmd    w_cmd;
    t_status w_status;

    mpa_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid),
        .i_out_ready(i_out_ready), .i_status(w_status), .o_ready(o_ready),
        .o_out_valid(o_out_valid), .o_cmd(w_cmd)
    );

    mpa_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd),
        .i_atom_mass(i_atom_mass), .i_pos_x(i_pos_x), .i_pos_y(i_pos_y),
        .i_pos_z(i_pos_z), .i_is_origin(i_is_origin), .i_is_final(i_is_final),
        .o_status(w_status), .o_total_mass(o_total_mass),
        .o_com_x(o_com_x), .o_com_y(o_com_y), .o_com_z(o_com_z),
        .o_inertia_xx(o_inertia_xx), .o_inertia_yy(o_inertia_yy),
        .o_inertia_zz(o_inertia_zz), .o_inertia_xy(o_inertia_xy),
        .o_inertia_yz(o_inertia_yz), .o_inertia_xz(o_inertia_xz),
        .o_mass_zero(o_mass_zero)
    );

    // no new point while a result waits
    `MPA_SAME(a_no_ready_with_result, i_clk, i_rst_n, o_out_valid, !o_ready)
    // an accepted point is never followed at once by a result
    `MPA_NEXT(a_accept_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready && !o_out_valid)
    // zero mass forces a zero centre of mass
    `MPA_SAME(a_zero_com, i_clk, i_rst_n, o_out_valid && o_mass_zero,
        o_com_x == 21'sd0 && o_com_y == 21'sd0 && o_com_z == 21'sd0)
endmodule
